[src/block_range_gain_gate_core_defines.svh]
// ----------------------------------------------------------------------------
// Block range gain gate assertion macros
// Concurrent assertion wrappers shared by the controller and the datapath.
// ----------------------------------------------------------------------------
`ifndef BLOCK_RANGE_GAIN_GATE_CORE_DEFINES_SVH
`define BLOCK_RANGE_GAIN_GATE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define BRGG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("brgg: same-cycle assertion failed");

`define BRGG_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("brgg: next-cycle assertion failed");

`else

`define BRGG_ASSERT_IMP(label, clk, rst, ante, cons)

`define BRGG_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

[src/brgg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block range gain gate package
// Sizes, register codes, reset values and the types shared by the modules.
// ----------------------------------------------------------------------------
package brgg_pkg;

   localparam int BLOCK_MAX      = 64;
   localparam int SAMPLE_BITS    = 16;
   localparam int IDX_BITS       = $clog2(BLOCK_MAX);
   localparam int CNT_BITS       = $clog2(BLOCK_MAX + 1);
   localparam int ADDR_BITS      = IDX_BITS + 1;
   localparam int RAM_DEPTH      = 2 * BLOCK_MAX;
   localparam int CFG_BITS       = 16;
   localparam int LEN_FIELD_BITS = 7;
   localparam int LEN_BITS       = (LEN_FIELD_BITS > CNT_BITS) ? LEN_FIELD_BITS : CNT_BITS;
   localparam int GAIN_BITS      = 16;
   localparam int GAIN_FRAC      = 12;
   localparam int DIFF_BITS      = ((SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS) + 1;
   localparam int SPAN_BITS      = SAMPLE_BITS + 1;
   localparam int RANGE_BITS     = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS;
   localparam int PROD_BITS      = SAMPLE_BITS + GAIN_BITS;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLOCK_LEN       = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAMPLE_OFFSET   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANGE_THRESHOLD = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_ACTIVE     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_QUIET      = 3'd4;

   localparam logic [LEN_FIELD_BITS-1:0] BLOCK_LEN_RESET       = 7'd16;
   localparam logic signed [CFG_BITS-1:0] SAMPLE_OFFSET_RESET  = 16'sd0;
   localparam logic [CFG_BITS-1:0] RANGE_THRESHOLD_RESET       = 16'd1000;
   localparam logic signed [GAIN_BITS-1:0] GAIN_ACTIVE_RESET   = 16'sd4096;
   localparam logic signed [GAIN_BITS-1:0] GAIN_QUIET_RESET    = 16'sd4096;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_READ,
      ST_MUL,
      ST_SAT,
      ST_OUT,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic update;
      logic rd;
      logic mul;
      logic load_out;
      logic advance;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic block_done;
      logic fin_valid;
      logic drain_last;
   } status_type;

endpackage

[src/brgg_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block range gain gate sample RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module brgg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/brgg_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block range gain gate controller
// Sequences sample intake, block drain and block commit for the datapath.
// ----------------------------------------------------------------------------
`include "block_range_gain_gate_core_defines.svh"

module brgg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  brgg_pkg::status_type status,
   output brgg_pkg::cmd_type    cmd
);

   brgg_pkg::state_type state_ff;
   brgg_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brgg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         brgg_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = brgg_pkg::ST_UPDATE;
            end
         end
         brgg_pkg::ST_UPDATE: begin
            if (!status.block_done) begin
               state_in = brgg_pkg::ST_IDLE;
            end else if (status.fin_valid) begin
               state_in = brgg_pkg::ST_READ;
            end else begin
               state_in = brgg_pkg::ST_COMMIT;
            end
         end
         brgg_pkg::ST_READ:   state_in = brgg_pkg::ST_MUL;
         brgg_pkg::ST_MUL:    state_in = brgg_pkg::ST_SAT;
         brgg_pkg::ST_SAT:    state_in = brgg_pkg::ST_OUT;
         brgg_pkg::ST_OUT: begin
            if (rsp_ready) begin
               state_in = status.drain_last ? brgg_pkg::ST_COMMIT : brgg_pkg::ST_READ;
            end
         end
         brgg_pkg::ST_COMMIT: state_in = brgg_pkg::ST_IDLE;
         default:             state_in = brgg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = (state_ff == brgg_pkg::ST_IDLE);
      rsp_valid    = (state_ff == brgg_pkg::ST_OUT);
      cmd.capture  = (state_ff == brgg_pkg::ST_IDLE) && req_valid;
      cmd.update   = (state_ff == brgg_pkg::ST_UPDATE);
      cmd.rd       = (state_ff == brgg_pkg::ST_READ);
      cmd.mul      = (state_ff == brgg_pkg::ST_MUL);
      cmd.load_out = (state_ff == brgg_pkg::ST_SAT);
      cmd.advance  = (state_ff == brgg_pkg::ST_OUT) && rsp_ready && !status.drain_last;
      cmd.commit   = (state_ff == brgg_pkg::ST_COMMIT);
   end

   `BRGG_ASSERT_IMP(a_one_side_busy, clock, reset, rsp_valid, !req_ready)
   `BRGG_ASSERT_NXT(a_out_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `BRGG_ASSERT_NXT(a_drain_needs_block, clock, reset, cmd.update && status.block_done && !status.fin_valid, cmd.commit)

endmodule

[src/brgg_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block range gain gate datapath
// Holds the registers, the ping-pong sample store, range tracking and scaling.
// ----------------------------------------------------------------------------
`include "block_range_gain_gate_core_defines.svh"

module brgg_dp (
   input  logic                                       clock,
   input  logic                                       reset,
   input  brgg_pkg::cmd_type                          cmd,
   output brgg_pkg::status_type                       status,
   input  logic                                       csr_we,
   input  logic [brgg_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [brgg_pkg::CFG_BITS-1:0]              csr_data,
   input  logic signed [brgg_pkg::SAMPLE_BITS-1:0]    sample_in,
   output logic signed [brgg_pkg::SAMPLE_BITS-1:0]    sample_out,
   output logic                                       last_of_block,
   output logic                                       block_was_active
);

   logic [brgg_pkg::LEN_FIELD_BITS-1:0]       block_len_ff;
   logic signed [brgg_pkg::CFG_BITS-1:0]      offset_ff;
   logic [brgg_pkg::CFG_BITS-1:0]             threshold_ff;
   logic signed [brgg_pkg::GAIN_BITS-1:0]     gain_active_ff;
   logic signed [brgg_pkg::GAIN_BITS-1:0]     gain_quiet_ff;

   logic signed [brgg_pkg::SAMPLE_BITS-1:0]   sample_ff;
   logic signed [brgg_pkg::SAMPLE_BITS-1:0]   sample_in_sat;
   logic signed [brgg_pkg::DIFF_BITS-1:0]     diff_w;

   logic [brgg_pkg::CNT_BITS-1:0]             fill_cnt_ff;
   logic signed [brgg_pkg::SAMPLE_BITS-1:0]   min_ff;
   logic signed [brgg_pkg::SAMPLE_BITS-1:0]   max_ff;
   logic                                      bank_ff;

   logic                                      fin_valid_ff;
   logic                                      fin_active_ff;
   logic signed [brgg_pkg::GAIN_BITS-1:0]     fin_gain_ff;
   logic [brgg_pkg::CNT_BITS-1:0]             fin_count_ff;
   logic [brgg_pkg::IDX_BITS-1:0]             drain_idx_ff;

   logic [brgg_pkg::LEN_BITS-1:0]             len_w;
   logic signed [brgg_pkg::SPAN_BITS-1:0]     span_w;
   logic [brgg_pkg::RANGE_BITS-1:0]           range_w;
   logic                                      act_w;

   logic [brgg_pkg::ADDR_BITS-1:0]            wr_addr;
   logic [brgg_pkg::ADDR_BITS-1:0]            rd_addr;
   logic [brgg_pkg::SAMPLE_BITS-1:0]          rd_data;

   logic signed [brgg_pkg::PROD_BITS-1:0]     prod_in;
   logic signed [brgg_pkg::PROD_BITS-1:0]     prod_ff;
   logic signed [brgg_pkg::PROD_BITS-1:0]     shifted_w;
   logic signed [brgg_pkg::SAMPLE_BITS-1:0]   scaled_w;

   logic signed [brgg_pkg::SAMPLE_BITS-1:0]   sample_out_ff;
   logic                                      last_ff;
   logic                                      active_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         block_len_ff   <= brgg_pkg::BLOCK_LEN_RESET;
         offset_ff      <= brgg_pkg::SAMPLE_OFFSET_RESET;
         threshold_ff   <= brgg_pkg::RANGE_THRESHOLD_RESET;
         gain_active_ff <= brgg_pkg::GAIN_ACTIVE_RESET;
         gain_quiet_ff  <= brgg_pkg::GAIN_QUIET_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            brgg_pkg::CSR_BLOCK_LEN:
               block_len_ff <= csr_data[brgg_pkg::LEN_FIELD_BITS-1:0];
            brgg_pkg::CSR_SAMPLE_OFFSET:   offset_ff      <= $signed(csr_data);
            brgg_pkg::CSR_RANGE_THRESHOLD: threshold_ff   <= csr_data;
            brgg_pkg::CSR_GAIN_ACTIVE:     gain_active_ff <= $signed(csr_data);
            brgg_pkg::CSR_GAIN_QUIET:      gain_quiet_ff  <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   // Offset removal with saturation at intake.
   assign diff_w = brgg_pkg::DIFF_BITS'(sample_in) - brgg_pkg::DIFF_BITS'(offset_ff);

   always_comb begin
      if (diff_w > brgg_pkg::DIFF_BITS'(brgg_pkg::SAMPLE_MAX)) begin
         sample_in_sat = brgg_pkg::SAMPLE_MAX;
      end else if (diff_w < brgg_pkg::DIFF_BITS'(brgg_pkg::SAMPLE_MIN)) begin
         sample_in_sat = brgg_pkg::SAMPLE_MIN;
      end else begin
         sample_in_sat = diff_w[brgg_pkg::SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= sample_in_sat;
      end
   end

   // Effective block length and completion check.
   always_comb begin
      len_w = brgg_pkg::LEN_BITS'(block_len_ff);
      if (len_w == '0) begin
         len_w = brgg_pkg::LEN_BITS'(1);
      end else if (len_w > brgg_pkg::LEN_BITS'(brgg_pkg::BLOCK_MAX)) begin
         len_w = brgg_pkg::LEN_BITS'(brgg_pkg::BLOCK_MAX);
      end
   end

   assign status.block_done =
      (brgg_pkg::LEN_BITS'(fill_cnt_ff) + brgg_pkg::LEN_BITS'(1)) >= len_w;
   assign status.fin_valid  = fin_valid_ff;
   assign status.drain_last =
      (brgg_pkg::CNT_BITS'(drain_idx_ff) + brgg_pkg::CNT_BITS'(1)) == fin_count_ff;

   // Range of the filling block and its gain decision.
   assign span_w  = brgg_pkg::SPAN_BITS'(max_ff) - brgg_pkg::SPAN_BITS'(min_ff);
   assign range_w = brgg_pkg::RANGE_BITS'(span_w[brgg_pkg::SAMPLE_BITS-1:0]);
   assign act_w   = range_w > brgg_pkg::RANGE_BITS'(threshold_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_cnt_ff   <= '0;
         min_ff        <= brgg_pkg::SAMPLE_MAX;
         max_ff        <= brgg_pkg::SAMPLE_MIN;
         bank_ff       <= 1'b0;
         fin_valid_ff  <= 1'b0;
         fin_active_ff <= 1'b0;
         drain_idx_ff  <= '0;
      end else begin
         if (cmd.update) begin
            fill_cnt_ff <= fill_cnt_ff + brgg_pkg::CNT_BITS'(1);
            if (sample_ff < min_ff) begin
               min_ff <= sample_ff;
            end
            if (sample_ff > max_ff) begin
               max_ff <= sample_ff;
            end
         end
         if (cmd.advance) begin
            drain_idx_ff <= drain_idx_ff + brgg_pkg::IDX_BITS'(1);
         end
         if (cmd.commit) begin
            fin_valid_ff  <= 1'b1;
            fin_active_ff <= act_w;
            bank_ff       <= ~bank_ff;
            fill_cnt_ff   <= '0;
            min_ff        <= brgg_pkg::SAMPLE_MAX;
            max_ff        <= brgg_pkg::SAMPLE_MIN;
            drain_idx_ff  <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         fin_gain_ff  <= act_w ? gain_active_ff : gain_quiet_ff;
         fin_count_ff <= fill_cnt_ff;
      end
   end

   // One bank fills while the other holds the finished block.
   assign wr_addr = {bank_ff, fill_cnt_ff[brgg_pkg::IDX_BITS-1:0]};
   assign rd_addr = {~bank_ff, drain_idx_ff};

   brgg_ram #(
      .WIDTH (brgg_pkg::SAMPLE_BITS),
      .DEPTH (brgg_pkg::RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (wr_addr),
      .wr_data (sample_ff),
      .rd_en   (cmd.rd),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Q4.12 scaling: multiply, floor shift, saturate.
   assign prod_in = $signed(rd_data) * fin_gain_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
   end

   assign shifted_w = prod_ff >>> brgg_pkg::GAIN_FRAC;

   always_comb begin
      if (shifted_w > brgg_pkg::PROD_BITS'(brgg_pkg::SAMPLE_MAX)) begin
         scaled_w = brgg_pkg::SAMPLE_MAX;
      end else if (shifted_w < brgg_pkg::PROD_BITS'(brgg_pkg::SAMPLE_MIN)) begin
         scaled_w = brgg_pkg::SAMPLE_MIN;
      end else begin
         scaled_w = shifted_w[brgg_pkg::SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         sample_out_ff <= scaled_w;
         last_ff       <= status.drain_last;
         active_ff     <= fin_active_ff;
      end
   end

   assign sample_out       = sample_out_ff;
   assign last_of_block    = last_ff;
   assign block_was_active = active_ff;

   `BRGG_ASSERT_IMP(a_fill_bounded, clock, reset, 1'b1, fill_cnt_ff <= brgg_pkg::CNT_BITS'(brgg_pkg::BLOCK_MAX))
   `BRGG_ASSERT_NXT(a_commit_clears, clock, reset, cmd.commit, (fill_cnt_ff == '0) && fin_valid_ff)
   `BRGG_ASSERT_IMP(a_drain_in_block, clock, reset, fin_valid_ff, brgg_pkg::CNT_BITS'(drain_idx_ff) < fin_count_ff)
   `BRGG_ASSERT_IMP(a_min_le_max, clock, reset, fill_cnt_ff != '0, min_ff <= max_ff)

endmodule

[src/block_range_gain_gate_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block range gain gate core
// Removes an offset from each sample, gathers samples into blocks, and emits
// each finished block scaled by a gain chosen from its peak-to-peak range.
// ----------------------------------------------------------------------------
// An input beat that does not complete a block goes from idle to the update
// state and back. A beat that completes a block drains the previous block,
// each of its samples passing the RAM read, the registered multiply and the
// saturating output register in turn, and each output beat held until
// rsp_ready is seen; the new block is then committed. No input beat is
// taken while a block drains. The first block emits nothing.
// Configuration writes are accepted in every cycle and are meant for times
// when no block is draining.
module block_range_gain_gate_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [brgg_pkg::SAMPLE_BITS-1:0] req_sample_in,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [brgg_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                                    rsp_last_of_block,
   output logic                                    rsp_block_was_active,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [brgg_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [brgg_pkg::CFG_BITS-1:0]           csr_data
);

   brgg_pkg::cmd_type    cmd;
   brgg_pkg::status_type status;

   assign csr_ready = 1'b1;

   brgg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   brgg_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_we           (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .sample_in        (req_sample_in),
      .sample_out       (rsp_sample_out),
      .last_of_block    (rsp_last_of_block),
      .block_was_active (rsp_block_was_active)
   );

endmodule
